// File: sv/trme_pkg.sv
package trme_pkg;

  localparam int unsigned MEM_WORDS = 50;
  localparam int unsigned NUM_REGS  = 5;
  localparam int unsigned MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned RF_AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LINE_W    = 16;

  localparam logic [2:0] MODE_MOV = 3'd0;
  localparam logic [2:0] MODE_ADD = 3'd1;
  localparam logic [2:0] MODE_SUB = 3'd2;
  localparam logic [2:0] MODE_PRN = 3'd3;
  localparam logic [2:0] MODE_JMP = 3'd4;
  localparam logic [2:0] MODE_JPN = 3'd5;
  localparam logic [2:0] MODE_HLT = 3'd6;

  localparam logic DST_REG = 1'b0;
  localparam logic DST_MEM = 1'b1;

  localparam logic [1:0] SRC_REG = 2'd0;
  localparam logic [1:0] SRC_MEM = 2'd1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ADDR   = 2'd1;
  localparam logic [1:0] ST_TARGET = 2'd2;
  localparam logic [1:0] ST_HALTED = 2'd3;

  typedef struct packed {
    logic [2:0]               mode;
    logic                     dest_kind;
    logic [IDX_W-1:0]         dest_index;
    logic [1:0]               src_kind;
    logic [IDX_W-1:0]         src_index;
    logic signed [DATA_W-1:0] immediate;
    logic                     has_condition;
    logic [LINE_W-1:0]        target_line;
  } trme_in_t;

  typedef struct packed {
    logic                     print_valid;
    logic signed [DATA_W-1:0] print_value;
    logic                     branch_taken;
    logic [LINE_W-1:0]        next_line;
    logic                     halted;
    logic [1:0]               status;
  } trme_out_t;

  // State update produced by one executed instruction
  typedef struct packed {
    logic              rf_we;
    logic [RF_AW-1:0]  rf_addr;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [DATA_W-1:0] data;
    logic              halt_set;
  } trme_wr_t;

  function automatic logic reg_ok(input logic [IDX_W-1:0] idx);
    return ({1'b0, idx} < (IDX_W+1)'(NUM_REGS));
  endfunction

  function automatic logic mem_ok(input logic [IDX_W-1:0] idx);
    return ({1'b0, idx} < (IDX_W+1)'(MEM_WORDS));
  endfunction

  // Out-of-range indexes map to entry zero; those instructions never use the data
  function automatic logic [RF_AW-1:0] rf_addr(input logic [IDX_W-1:0] idx);
    return reg_ok(idx) ? idx[RF_AW-1:0] : '0;
  endfunction

  function automatic logic [MEM_AW-1:0] mem_addr(input logic [IDX_W-1:0] idx);
    return mem_ok(idx) ? idx[MEM_AW-1:0] : '0;
  endfunction

  // The one memory word an instruction may read
  function automatic logic [IDX_W-1:0] mem_index(input trme_in_t ins);
    logic arith;
    arith = (ins.mode == MODE_MOV) || (ins.mode == MODE_ADD) || (ins.mode == MODE_SUB);
    return (arith && (ins.dest_kind == DST_MEM)) ? ins.dest_index : ins.src_index;
  endfunction

endpackage

// File: sv/trme_ram.sv
module trme_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// File: sv/trme_exec.sv
module trme_exec import trme_pkg::*; (
  input  trme_in_t          instr_i,
  input  logic [DATA_W-1:0] rf_a_i,
  input  logic [DATA_W-1:0] rf_b_i,
  input  logic [DATA_W-1:0] mem_i,
  input  logic              halt_i,
  input  logic [LINE_W-1:0] prog_len_i,
  output trme_out_t         res_o,
  output trme_wr_t          wr_o
);

  logic              d_reg_ok;
  logic              s_reg_ok;
  logic              d_mem_ok;
  logic              s_mem_ok;
  logic              is_mov;
  logic [DATA_W-1:0] imm;
  logic [DATA_W-1:0] arith_b;
  logic [DATA_W-1:0] arith_a;
  logic [DATA_W-1:0] arith_y;

  assign d_reg_ok = reg_ok(instr_i.dest_index);
  assign s_reg_ok = reg_ok(instr_i.src_index);
  assign d_mem_ok = mem_ok(instr_i.dest_index);
  assign s_mem_ok = mem_ok(instr_i.src_index);
  assign is_mov   = (instr_i.mode == MODE_MOV);
  assign imm      = instr_i.immediate;

  // Single shared adder: first operand is the register, or memory for a memory destination
  always_comb begin
    arith_a = (instr_i.dest_kind == DST_MEM) ? mem_i : rf_a_i;
    case (instr_i.src_kind)
      SRC_REG: arith_b = rf_b_i;
      SRC_MEM: arith_b = mem_i;
      default: arith_b = imm;
    endcase
    if (instr_i.dest_kind == DST_MEM) begin
      arith_b = imm;
    end
    arith_y = (instr_i.mode == MODE_ADD) ? (arith_a + arith_b) : (arith_a - arith_b);
  end

  always_comb begin
    res_o    = '0;
    wr_o     = '0;
    wr_o.rf_addr  = rf_addr(instr_i.dest_index);
    wr_o.mem_addr = mem_addr(instr_i.dest_index);
    wr_o.data     = arith_y;

    if (halt_i) begin
      res_o.status = ST_HALTED;
    end else begin
      case (instr_i.mode)
        MODE_MOV, MODE_ADD, MODE_SUB: begin
          if (instr_i.dest_kind == DST_REG) begin
            if (!d_reg_ok) begin
              res_o.status = ST_ADDR;
            end else begin
              case (instr_i.src_kind)
                SRC_REG: begin
                  if (!s_reg_ok) begin
                    res_o.status = ST_ADDR;
                  end else begin
                    wr_o.rf_we = 1'b1;
                    if (is_mov) begin
                      // copies first operand into second
                      wr_o.rf_addr = rf_addr(instr_i.src_index);
                      wr_o.data    = rf_a_i;
                    end
                  end
                end
                SRC_MEM: begin
                  if (!s_mem_ok) begin
                    res_o.status = ST_ADDR;
                  end else if (is_mov) begin
                    wr_o.mem_we   = 1'b1;
                    wr_o.mem_addr = mem_addr(instr_i.src_index);
                    wr_o.data     = rf_a_i;
                  end else begin
                    wr_o.rf_we = 1'b1;
                  end
                end
                default: begin
                  wr_o.rf_we = 1'b1;
                  if (is_mov) begin
                    wr_o.data = imm;
                  end
                end
              endcase
            end
          end else begin
            if (!d_mem_ok) begin
              res_o.status = ST_ADDR;
            end else begin
              case (instr_i.src_kind)
                SRC_REG: begin
                  if (!s_reg_ok) begin
                    res_o.status = ST_ADDR;
                  end else if (is_mov) begin
                    wr_o.rf_we   = 1'b1;
                    wr_o.rf_addr = rf_addr(instr_i.src_index);
                    wr_o.data    = mem_i;
                  end
                end
                SRC_MEM: begin
                  // memory to memory has no effect
                end
                default: begin
                  wr_o.mem_we = 1'b1;
                  if (is_mov) begin
                    wr_o.data = imm;
                  end
                end
              endcase
            end
          end
        end
        MODE_PRN: begin
          case (instr_i.src_kind)
            SRC_REG: begin
              if (!s_reg_ok) begin
                res_o.status = ST_ADDR;
              end else begin
                res_o.print_value = rf_b_i;
              end
            end
            SRC_MEM: begin
              if (!s_mem_ok) begin
                res_o.status = ST_ADDR;
              end else begin
                res_o.print_value = mem_i;
              end
            end
            default: res_o.print_value = imm;
          endcase
          res_o.print_valid = (res_o.status == ST_OK);
        end
        MODE_JMP, MODE_JPN: begin
          if ((instr_i.target_line == '0) || (instr_i.target_line > prog_len_i)) begin
            res_o.status = ST_TARGET;
          end else if (!instr_i.has_condition) begin
            res_o.branch_taken = 1'b1;
          end else if (!d_reg_ok) begin
            res_o.status = ST_ADDR;
          end else if (instr_i.mode == MODE_JMP) begin
            res_o.branch_taken = (rf_a_i == '0);
          end else begin
            res_o.branch_taken = (rf_a_i == '0) || rf_a_i[DATA_W-1];
          end
          if (res_o.branch_taken) begin
            res_o.next_line = instr_i.target_line;
          end
        end
        MODE_HLT: wr_o.halt_set = 1'b1;
        default: begin
        end
      endcase
    end
    res_o.halted = halt_i | wr_o.halt_set;
  end

endmodule

// File: sv/tiny_register_memory_executor_top.sv
// Executes one decoded instruction per input transfer on a machine with
// NUM_REGS 32-bit registers and MEM_WORDS 32-bit data words.
//
// Channels: in_data_i/in_valid_i/in_stall_o carries instructions, and
// out_data_o/out_valid_o/out_stall_i returns one result per instruction.
// A transfer happens on a clock edge with valid high and stall low.
// cfg_we_i/cfg_data_i writes program_length (jump target bound); write it
// only while no instruction is in flight.
//
// Timing: the edge that accepts an instruction reads its operands from the
// register file and data memory and loads it into the execute register; it
// executes, writes back and loads its result into the output register when
// the execute stage advances. Throughput is one instruction per cycle unless
// the output stalls; back-to-back dependent instructions use a write-back bypass.
//
// Reset clears registers, memory (valid bits), the halt flag and sets
// program_length to 1. When the receiver stalls, the result holds and the
// execute stage holds one more instruction; then in_stall_o rises.
module tiny_register_memory_executor_top import trme_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  trme_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output trme_out_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [LINE_W-1:0] cfg_data_i
);

  logic              in_xfer;
  logic              ex_adv;
  logic              ex_valid_q;
  trme_in_t          ex_q;
  logic              out_valid_q;
  trme_out_t         out_q;
  logic              halt_q;
  logic [LINE_W-1:0] prog_len_q;

  logic [RF_AW-1:0]  rf_ra;
  logic [RF_AW-1:0]  rf_rb;
  logic [MEM_AW-1:0] mem_ra;
  logic [DATA_W-1:0] rf_rd_a;
  logic [DATA_W-1:0] rf_rd_b;
  logic [DATA_W-1:0] mem_rd;
  logic [DATA_W-1:0] rf_a;
  logic [DATA_W-1:0] rf_b;
  logic [DATA_W-1:0] mem_op;

  logic              fwd_a_q;
  logic              fwd_b_q;
  logic              fwd_m_q;
  logic [DATA_W-1:0] fwd_data_q;

  trme_out_t         ex_res;
  trme_wr_t          ex_wr;
  logic              rf_we;
  logic              mem_we;

  assign ex_adv     = ex_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = ex_valid_q && out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign rf_we  = ex_adv && ex_wr.rf_we;
  assign mem_we = ex_adv && ex_wr.mem_we;

  assign rf_ra  = rf_addr(in_data_i.dest_index);
  assign rf_rb  = rf_addr(in_data_i.src_index);
  assign mem_ra = mem_addr(mem_index(in_data_i));

  // Register file: two copies, one per read port
  trme_ram #(.DEPTH(NUM_REGS), .WIDTH(DATA_W)) u_rf_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (rf_we),
    .waddr_i (ex_wr.rf_addr),
    .wdata_i (ex_wr.data),
    .re_i    (in_xfer),
    .raddr_i (rf_ra),
    .rdata_o (rf_rd_a)
  );

  trme_ram #(.DEPTH(NUM_REGS), .WIDTH(DATA_W)) u_rf_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (rf_we),
    .waddr_i (ex_wr.rf_addr),
    .wdata_i (ex_wr.data),
    .re_i    (in_xfer),
    .raddr_i (rf_rb),
    .rdata_o (rf_rd_b)
  );

  trme_ram #(.DEPTH(MEM_WORDS), .WIDTH(DATA_W)) u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (ex_wr.mem_addr),
    .wdata_i (ex_wr.data),
    .re_i    (in_xfer),
    .raddr_i (mem_ra),
    .rdata_o (mem_rd)
  );

  // Reads at the accept edge see old contents; catch the write landing on the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
      fwd_m_q <= 1'b0;
    end else if (in_xfer) begin
      fwd_a_q <= rf_we && (ex_wr.rf_addr == rf_ra);
      fwd_b_q <= rf_we && (ex_wr.rf_addr == rf_rb);
      fwd_m_q <= mem_we && (ex_wr.mem_addr == mem_ra);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      fwd_data_q <= ex_wr.data;
      ex_q       <= in_data_i;
    end
  end

  assign rf_a   = fwd_a_q ? fwd_data_q : rf_rd_a;
  assign rf_b   = fwd_b_q ? fwd_data_q : rf_rd_b;
  assign mem_op = fwd_m_q ? fwd_data_q : mem_rd;

  trme_exec u_exec (
    .instr_i    (ex_q),
    .rf_a_i     (rf_a),
    .rf_b_i     (rf_b),
    .mem_i      (mem_op),
    .halt_i     (halt_q),
    .prog_len_i (prog_len_q),
    .res_o      (ex_res),
    .wr_o       (ex_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      halt_q      <= 1'b0;
      prog_len_q  <= LINE_W'(1);
    end else begin
      if (in_xfer) begin
        ex_valid_q <= 1'b1;
      end else if (ex_adv) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ex_adv && ex_wr.halt_set) begin
        halt_q <= 1'b1;
      end
      if (cfg_we_i) begin
        prog_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_adv) begin
      out_q <= ex_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/trme_checker.sv
module trme_checker import trme_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input trme_out_t out_data_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result does not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Halted machine does nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_HALTED) |->
      out_data_o.halted && !out_data_o.print_valid && !out_data_o.branch_taken)
    else $error("activity reported on a halted machine");

  // Valid jump targets are never zero, and next_line is zero without a branch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.branch_taken == (out_data_o.next_line != '0)))
    else $error("branch flag and next line disagree");

  // Print and branch come from different instructions, and only on success
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.print_valid || out_data_o.branch_taken) |->
      (out_data_o.status == ST_OK) && !(out_data_o.print_valid && out_data_o.branch_taken))
    else $error("print or branch reported with an error");

endmodule

bind tiny_register_memory_executor_top trme_checker u_trme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
